>>> sv/wec_pkg.sv
`default_nettype none
package wec_pkg;

  localparam int unsigned MAX_EVENTS_DEF = 256;

  // configuration port
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 15;
  localparam logic [CFG_IW-1:0] REG_HMOD_WIN = 3'd0;
  localparam logic [CFG_IW-1:0] REG_HMEM_WIN = 3'd1;
  localparam logic [CFG_IW-1:0] REG_MMEM_WIN = 3'd2;
  localparam logic [CFG_IW-1:0] REG_GEN_WIN  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_CAPACITY = 3'd4;

  // commands
  localparam logic [1:0] CMD_OBSERVE   = 2'd0;
  localparam logic [1:0] CMD_CORRELATE = 2'd1;
  localparam logic [1:0] CMD_CLEAR     = 2'd2;

  // event kinds
  localparam logic [2:0] KIND_HANDLE = 3'd0;
  localparam logic [2:0] KIND_IMAGE  = 3'd1;
  localparam logic [2:0] KIND_MEM    = 3'd2;
  localparam logic [2:0] KIND_MEM_PE = 3'd3;

  // window limits and thresholds
  localparam logic [14:0] HMOD_WIN_MAX = 15'd5000;
  localparam logic [14:0] HMEM_WIN_MAX = 15'd5000;
  localparam logic [14:0] MMEM_WIN_MAX = 15'd10000;
  localparam logic [14:0] GEN_WIN_MAX  = 15'd30000;
  localparam logic [8:0]  CAP_MIN      = 9'd64;
  localparam logic [9:0]  ANOMALY_MIN  = 10'd800;
  localparam logic [9:0]  QUALITY_MIN  = 10'd750;

  // boost weights, per mille
  localparam logic [10:0] BOOST_TGT  = 11'd60;
  localparam logic [10:0] BOOST_SRC  = 11'd100;
  localparam logic [10:0] BOOST_TEMP = 11'd60;
  localparam logic [10:0] BOOST_HMOD = 11'd280;
  localparam logic [10:0] BOOST_HMEM = 11'd320;
  localparam logic [10:0] BOOST_MMEM = 11'd200;
  localparam logic [10:0] BOOST_CAP  = 11'd900;

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] time_ms;
    logic [2:0]  kind;
    logic [31:0] source_id;
    logic [31:0] target_id;
    logic [9:0]  anomaly_pm;
    logic [9:0]  quality_pm;
    logic [31:0] seq_number;
  } in_item_t;

  typedef struct packed {
    logic        same_target_seen;
    logic        same_source_seen;
    logic        temporal_near;
    logic        handle_then_module;
    logic        handle_then_memory;
    logic        module_then_memory;
    logic [8:0]  edge_count;
    logic        relation_valid;
    logic [9:0]  boost_pm;
  } out_item_t;

  // one stored event
  typedef struct packed {
    logic [47:0] time_ms;
    logic [2:0]  kind;
    logic [31:0] source_id;
    logic [31:0] target_id;
    logic [9:0]  anomaly_pm;
    logic [9:0]  quality_pm;
    logic [31:0] seq_number;
  } entry_t;

  // compare unit verdict on one entry
  typedef struct packed {
    logic future;
    logic over_gen;
    logic in_window;
    logic tgt_match;
    logic src_match;
    logic hmod;
    logic hmem;
    logic mmem;
  } eval_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OBS_WR,
    S_EV_RD,
    S_EV_CHK,
    S_SCAN,
    S_DUP_SEQ,
    S_DUP_WAIT,
    S_DUP_SCAN,
    S_FIN
  } state_t;

  function automatic logic [14:0] clamp_win(input logic [14:0] v, input logic [14:0] hi);
    logic [14:0] r;
    r = v;
    if (v == 15'd0) r = 15'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/wec_if.sv
`default_nettype none
interface wec_in_if;
  import wec_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wec_out_if;
  import wec_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/wec_mem.sv
`default_nettype none
module wec_mem #(
  parameter int unsigned DEPTH = wec_pkg::MAX_EVENTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire wec_pkg::entry_t          wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output wec_pkg::entry_t               rd_data
);
  import wec_pkg::*;

  entry_t mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

>>> sv/wec_eval.sv
`default_nettype none
module wec_eval (
  input  wire wec_pkg::entry_t ent,
  input  wire logic [47:0]     now,
  input  wire logic [2:0]      cur,
  input  wire logic [31:0]     src,
  input  wire logic [31:0]     tgt,
  input  wire logic [14:0]     w_hmod,
  input  wire logic [14:0]     w_hmem,
  input  wire logic [14:0]     w_mmem,
  input  wire logic [14:0]     w_gen,
  output wec_pkg::eval_t       res
);
  import wec_pkg::*;

  logic [47:0] delta;
  logic [14:0] win;
  logic        cur_mem;
  logic        base;
  logic        pk_handle;
  logic        pk_image;

  always_comb begin
    cur_mem   = (cur == KIND_MEM) || (cur == KIND_MEM_PE);
    pk_handle = ent.kind == KIND_HANDLE;
    pk_image  = ent.kind == KIND_IMAGE;
    delta     = now - ent.time_ms;

    // kind-pair window
    priority if (cur == KIND_IMAGE && pk_handle) begin
      win = w_hmod;
    end else if (cur_mem && pk_handle) begin
      win = w_hmem;
    end else if (cur_mem && pk_image) begin
      win = w_mmem;
    end else begin
      win = w_gen;
    end

    res.future    = now < ent.time_ms;
    res.over_gen  = delta > {33'd0, w_gen};
    res.in_window = !res.future && !res.over_gen;
    res.tgt_match = ent.target_id == tgt;
    res.src_match = ent.source_id == src;
    base          = res.in_window && res.tgt_match && (delta <= {33'd0, win});
    res.hmem      = base && cur_mem && pk_handle && res.src_match;
    res.mmem      = base && cur_mem && pk_image && (ent.anomaly_pm >= ANOMALY_MIN)
                    && (ent.quality_pm >= QUALITY_MIN);
    res.hmod      = base && (cur == KIND_IMAGE) && pk_handle && res.src_match;
  end
endmodule
`default_nettype wire

>>> sv/windowed_event_correlator_core.sv
// Channel  | Dir | Transaction
// in_ch    | in  | one command: observe, correlate or clear
// out_ch   | out | one correlation result per correlate command
// cfg_*    | in  | register write, one per cycle with cfg_we high
//
// Observe: append, then evict from the oldest end. Clear: empties the ring from idle.
// Correlate: a scan over the N stored events, then an edge pass that runs a
// duplicate check of each edge event at ring position i against the positions below
// i, then the hand-over of the result; every cycle costs one read of the event memory.
// Synchronous active-low reset empties the ring; memory contents are not cleared.
// in_ch is ready only when idle; a result waits in the output register and
// blocks the next correlate at its end only.
`default_nettype none
module windowed_event_correlator_core #(
  parameter int unsigned MAX_EVENTS = wec_pkg::MAX_EVENTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  wec_in_if.sink                          in_ch,
  wec_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [wec_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [wec_pkg::CFG_DW-1:0] cfg_data
);
  import wec_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_EVENTS);
  localparam int unsigned CNTW = AW + 1;
  localparam int unsigned EW   = (CNTW > 9) ? CNTW : 9;
  localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_EVENTS);

  // configuration registers
  logic [12:0] hmod_win_r;
  logic [12:0] hmem_win_r;
  logic [13:0] mmem_win_r;
  logic [14:0] gen_win_r;
  logic [8:0]  cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hmod_win_r <= 13'd2000;
      hmem_win_r <= 13'd2000;
      mmem_win_r <= 14'd5000;
      gen_win_r  <= 15'd10000;
      cap_r      <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HMOD_WIN: hmod_win_r <= cfg_data[12:0];
        REG_HMEM_WIN: hmem_win_r <= cfg_data[12:0];
        REG_MMEM_WIN: mmem_win_r <= cfg_data[13:0];
        REG_GEN_WIN:  gen_win_r  <= cfg_data;
        REG_CAPACITY: cap_r      <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // effective windows and capacity
  logic [14:0]     w_hmod, w_hmem, w_mmem, w_gen;
  logic [EW-1:0]   cap_ext;
  logic [CNTW-1:0] eff_cap;

  always_comb begin
    w_hmod  = clamp_win({2'd0, hmod_win_r}, HMOD_WIN_MAX);
    w_hmem  = clamp_win({2'd0, hmem_win_r}, HMEM_WIN_MAX);
    w_mmem  = clamp_win({1'd0, mmem_win_r}, MMEM_WIN_MAX);
    w_gen   = clamp_win(gen_win_r, GEN_WIN_MAX);
    cap_ext = EW'(cap_r);
    if (cap_ext < EW'(CAP_MIN)) cap_ext = EW'(CAP_MIN);
    if (cap_ext > EW'(MAX_EVENTS)) cap_ext = EW'(MAX_EVENTS);
    eff_cap = cap_ext[CNTW-1:0];
  end

  // ring position to memory slot, with wrap
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CNTW-1:0] off);
    logic [CNTW:0] s;
    s = {1'b0, 1'b0, base} + {1'b0, off};
    if (s >= {1'b0, MAX_CNT}) s = s - {1'b0, MAX_CNT};
    return s[AW-1:0];
  endfunction

  // state
  state_t          state_r, state_nxt;
  in_item_t        q_r, q_nxt;
  logic [AW-1:0]   oldest_r, oldest_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [CNTW-1:0] idx_r, idx_nxt;
  logic [CNTW-1:0] pos_r, pos_nxt;
  logic            vld_r, vld_nxt;
  logic [CNTW-1:0] jdx_r, jdx_nxt;
  logic [31:0]     seqi_r, seqi_nxt;
  logic            dup_r, dup_nxt;
  logic [MAX_EVENTS-1:0] edge_r, edge_nxt;
  logic            st_r, st_nxt, ss_r, ss_nxt;
  logic            hmod_r, hmod_nxt, hmem_r, hmem_nxt, mmem_r, mmem_nxt;
  logic            any_r, any_nxt;
  logic [CNTW-1:0] edges_r, edges_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  // memory port and compare unit
  logic            wr_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  entry_t          wr_data, rd_data;
  eval_t           ev;
  logic            full;
  logic [10:0]     boost;

  wec_mem #(.DEPTH(MAX_EVENTS)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wec_eval u_eval (
    .ent    (rd_data),
    .now    (q_r.time_ms),
    .cur    (q_r.kind),
    .src    (q_r.source_id),
    .tgt    (q_r.target_id),
    .w_hmod (w_hmod),
    .w_hmem (w_hmem),
    .w_mmem (w_mmem),
    .w_gen  (w_gen),
    .res    (ev)
  );

  always_comb begin
    wr_data.time_ms    = q_r.time_ms;
    wr_data.kind       = q_r.kind;
    wr_data.source_id  = q_r.source_id;
    wr_data.target_id  = q_r.target_id;
    wr_data.anomaly_pm = q_r.anomaly_pm;
    wr_data.quality_pm = q_r.quality_pm;
    wr_data.seq_number = q_r.seq_number;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    q_r     <= q_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    jdx_r   <= jdx_nxt;
    seqi_r  <= seqi_nxt;
    dup_r   <= dup_nxt;
    edge_r  <= edge_nxt;
    st_r    <= st_nxt;
    ss_r    <= ss_nxt;
    hmod_r  <= hmod_nxt;
    hmem_r  <= hmem_nxt;
    mmem_r  <= mmem_nxt;
    any_r   <= any_nxt;
    edges_r <= edges_nxt;
    out_r   <= out_nxt;
  end

  assign in_ch.ready  = state_r == S_IDLE;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    vld_nxt       = 1'b0;
    jdx_nxt       = jdx_r;
    seqi_nxt      = seqi_r;
    dup_nxt       = dup_r;
    edge_nxt      = edge_r;
    st_nxt        = st_r;
    ss_nxt        = ss_r;
    hmod_nxt      = hmod_r;
    hmem_nxt      = hmem_r;
    mmem_nxt      = mmem_r;
    any_nxt       = any_r;
    edges_nxt     = edges_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    wr_en         = 1'b0;
    full          = count_r == MAX_CNT;
    wr_addr       = full ? oldest_r : ring_add(oldest_r, count_r);
    rd_addr       = oldest_r;
    boost         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          q_nxt = in_ch.data;
          unique case (in_ch.data.command)
            CMD_OBSERVE: state_nxt = S_OBS_WR;
            CMD_CORRELATE: begin
              idx_nxt   = '0;
              edge_nxt  = '0;
              st_nxt    = 1'b0;
              ss_nxt    = 1'b0;
              hmod_nxt  = 1'b0;
              hmem_nxt  = 1'b0;
              mmem_nxt  = 1'b0;
              any_nxt   = 1'b0;
              edges_nxt = '0;
              state_nxt = S_SCAN;
            end
            CMD_CLEAR: begin
              oldest_nxt = '0;
              count_nxt  = '0;
            end
            default: ;
          endcase
        end
      end

      // append, dropping the oldest when the ring is full
      S_OBS_WR: begin
        wr_en = 1'b1;
        if (full) begin
          oldest_nxt = ring_add(oldest_r, CNTW'(1));
        end else begin
          count_nxt = count_r + CNTW'(1);
        end
        state_nxt = S_EV_RD;
      end

      S_EV_RD: begin
        rd_addr   = oldest_r;
        state_nxt = S_EV_CHK;
      end

      // evict while too old or over capacity
      S_EV_CHK: begin
        if ((!ev.future && ev.over_gen) || (count_r > eff_cap)) begin
          oldest_nxt = ring_add(oldest_r, CNTW'(1));
          count_nxt  = count_r - CNTW'(1);
          state_nxt  = (count_r > CNTW'(1)) ? S_EV_RD : S_IDLE;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // first pass: flags and edge marks, one entry per cycle
      S_SCAN: begin
        rd_addr = ring_add(oldest_r, idx_r);
        if (idx_r < count_r) begin
          vld_nxt = 1'b1;
          pos_nxt = idx_r;
          idx_nxt = idx_r + CNTW'(1);
        end
        if (vld_r && ev.in_window) begin
          if (ev.tgt_match) st_nxt = 1'b1;
          if (ev.src_match) ss_nxt = 1'b1;
          if (ev.hmod) hmod_nxt = 1'b1;
          if (ev.hmem) hmem_nxt = 1'b1;
          if (ev.mmem) mmem_nxt = 1'b1;
          if (ev.hmod || ev.hmem || ev.mmem) begin
            any_nxt = 1'b1;
            edge_nxt[pos_r[AW-1:0]] = 1'b1;
          end
        end
        if (idx_r >= count_r && !vld_r) begin
          idx_nxt   = '0;
          state_nxt = S_DUP_SEQ;
        end
      end

      // second pass: count distinct sequence numbers among edge events
      S_DUP_SEQ: begin
        rd_addr = ring_add(oldest_r, idx_r);
        if (idx_r >= count_r) begin
          state_nxt = S_FIN;
        end else if (!edge_r[idx_r[AW-1:0]]) begin
          idx_nxt = idx_r + CNTW'(1);
        end else begin
          state_nxt = S_DUP_WAIT;
        end
      end

      S_DUP_WAIT: begin
        seqi_nxt  = rd_data.seq_number;
        jdx_nxt   = '0;
        dup_nxt   = 1'b0;
        state_nxt = S_DUP_SCAN;
      end

      S_DUP_SCAN: begin
        rd_addr = ring_add(oldest_r, jdx_r);
        if (jdx_r < idx_r) begin
          vld_nxt = 1'b1;
          pos_nxt = jdx_r;
          jdx_nxt = jdx_r + CNTW'(1);
        end
        if (vld_r && edge_r[pos_r[AW-1:0]] && rd_data.seq_number == seqi_r) begin
          dup_nxt = 1'b1;
        end
        if (jdx_r >= idx_r && !vld_r) begin
          if (!dup_r) edges_nxt = edges_r + CNTW'(1);
          idx_nxt   = idx_r + CNTW'(1);
          state_nxt = S_DUP_SEQ;
        end
      end

      // build the result once the output register is free
      S_FIN: begin
        if (any_r && edges_r != '0) begin
          boost = BOOST_TEMP;
          if (st_r) boost = boost + BOOST_TGT;
          if (ss_r) boost = boost + BOOST_SRC;
          if (hmod_r) boost = boost + BOOST_HMOD;
          if (hmem_r) boost = boost + BOOST_HMEM;
          if (mmem_r) boost = boost + BOOST_MMEM;
          if (boost > BOOST_CAP) boost = BOOST_CAP;
        end
        if (!out_valid_r || out_ch.ready) begin
          out_nxt.same_target_seen   = st_r;
          out_nxt.same_source_seen   = ss_r;
          out_nxt.temporal_near      = any_r && edges_r != '0;
          out_nxt.handle_then_module = hmod_r;
          out_nxt.handle_then_memory = hmem_r;
          out_nxt.module_then_memory = mmem_r;
          out_nxt.edge_count         = 9'(edges_r);
          out_nxt.relation_valid     = any_r && edges_r != '0;
          out_nxt.boost_pm           = boost[9:0];
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> sv/wec_checker.sv
`default_nettype none
module wec_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire wec_pkg::out_item_t out_data
);
  import wec_pkg::*;

  // a held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // temporal flag follows relation
  a_temporal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.temporal_near == out_data.relation_valid)
    else $error("temporal_near differs from relation_valid");

  // no relation: no edge flags and no boost
  a_no_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.relation_valid |-> out_data.boost_pm == 10'd0
      && !out_data.handle_then_module && !out_data.handle_then_memory
      && !out_data.module_then_memory)
    else $error("edge reported without relation");

  // boost capped
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.boost_pm <= 10'd900)
    else $error("boost above cap");

  // nothing offered straight out of reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind windowed_event_correlator_core wec_checker u_wec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
`default_nettype wire
